// ===== sv/pf_pkg.sv =====
`default_nettype none

package pf_pkg;

    // Width of the number and of every factor.
    localparam int VALUE_BITS = 31;
    // Byte-aligned width of the tdata buses.
    localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    // Width of the divider's step counter, which holds VALUE_BITS itself.
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    // Status codes carried with every result word.
    localparam logic ST_FACTOR       = 1'b0;
    localparam logic ST_UNFACTORABLE = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;

    // Result of one serial division.
    typedef struct packed {
        logic   done;
        t_value quo;
        t_value rem;
    } t_div_res;

    // One result word offered by the controller to the output stage.
    typedef struct packed {
        logic   valid;
        t_value factor;
        logic   last;
        logic   status;
    } t_emit;

endpackage

`default_nettype wire

// ===== sv/pf_serial_div.sv =====
`default_nettype none

// Restoring divider: one quotient bit per cycle, VALUE_BITS quotient bits per division.
module pf_serial_div
    import pf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_value   i_dividend,
    input  wire t_value   i_divisor,
    output t_div_res      o_res
);

    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_value           r_rem;
    t_value           r_quo;
    t_value           r_div;

    logic [VALUE_BITS:0] shifted;
    logic [VALUE_BITS:0] diff;
    logic                fits;

    assign shifted = {r_rem, r_quo[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LOAD;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
            r_quo <= {r_quo[VALUE_BITS-2:0], fits};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

// ===== sv/pf_ctrl.sv =====
`default_nettype none

// Trial-division sequencer. The newest factor is held back one step so that
// the final one can carry the last mark.
module pf_ctrl
    import pf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_value   i_number,
    output logic          o_div_start,
    output t_value        o_div_dividend,
    output t_value        o_div_divisor,
    input  wire t_div_res i_div,
    output t_emit         o_emit,
    input  wire logic     i_emit_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_FINISH,
        S_EMIT,
        S_LAST_REST
    } t_state;

    t_state r_state;
    t_state r_ret;
    t_value r_rest;
    t_value r_d;
    logic   r_in_while;
    t_value r_pend;
    logic   r_have_pend;
    t_value r_factor;
    logic   r_last;
    logic   r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_in_while  <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_number < VALUE_BITS'(2)) begin
                            r_factor <= '0;
                            r_last   <= 1'b1;
                            r_status <= ST_UNFACTORABLE;
                            r_ret    <= S_IDLE;
                            r_state  <= S_EMIT;
                        end else begin
                            r_rest      <= i_number;
                            r_d         <= VALUE_BITS'(2);
                            r_in_while  <= 1'b0;
                            r_have_pend <= 1'b0;
                            r_state     <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div.done) begin
                        if (!r_in_while && (r_d > i_div.quo)) begin
                            r_state <= S_FINISH;
                        end else if (i_div.rem == '0) begin
                            // The divisor goes in; the previously held factor goes out.
                            r_rest      <= i_div.quo;
                            r_in_while  <= 1'b1;
                            r_pend      <= r_d;
                            r_have_pend <= 1'b1;
                            if (r_have_pend) begin
                                r_factor <= r_pend;
                                r_last   <= 1'b0;
                                r_status <= ST_FACTOR;
                                r_ret    <= S_START;
                                r_state  <= S_EMIT;
                            end else begin
                                r_state <= S_START;
                            end
                        end else begin
                            r_d        <= r_d + VALUE_BITS'(1);
                            r_in_while <= 1'b0;
                            r_state    <= S_START;
                        end
                    end
                end
                S_FINISH: begin
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                    if (!r_have_pend) begin
                        r_factor <= '0;
                        r_last   <= 1'b1;
                        r_status <= ST_UNFACTORABLE;
                    end else if (r_rest > VALUE_BITS'(1)) begin
                        r_factor <= r_pend;
                        r_last   <= 1'b0;
                        r_status <= ST_FACTOR;
                        r_ret    <= S_LAST_REST;
                    end else begin
                        r_factor <= r_pend;
                        r_last   <= 1'b1;
                        r_status <= ST_FACTOR;
                    end
                end
                S_LAST_REST: begin
                    r_factor <= r_rest;
                    r_last   <= 1'b1;
                    r_status <= ST_FACTOR;
                    r_ret    <= S_IDLE;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_emit_ready) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_div_start    = (r_state == S_START);
    assign o_div_dividend = r_rest;
    assign o_div_divisor  = r_d;

    assign o_emit.valid  = (r_state == S_EMIT);
    assign o_emit.factor = r_factor;
    assign o_emit.last   = r_last;
    assign o_emit.status = r_status;

endmodule

`default_nettype wire

// ===== sv/prime_factorizer_top.sv =====
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: number[VALUE_BITS-1:0], zero padding
// m_axis    out        tdata: factor[VALUE_BITS-1:0], zero padding;
//                      tlast: last; tuser: status
//
// Each trial divisor costs one serial division plus sequencing through the
// S_START and S_DIV states, and a number takes up to sqrt(number) trial
// divisors. The single bit-per-cycle divider is shared by all trial divisions.
// Reset is synchronous and active low and returns the sequencer to idle.
// A stalled output word holds the sequencer; a new number is taken only once
// the previous one has been fully handed to the output register.
module prime_factorizer_top
    import pf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // number, then zero padding
    input  wire logic [DATA_BITS-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // factor, then zero padding
    output logic [DATA_BITS-1:0]      m_axis_tdata,
    // last
    output logic                      m_axis_tlast,
    // status: 1 when the number is 0, 1 or prime
    output logic [0:0]                m_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready
);

    logic     div_start;
    t_value   div_dividend;
    t_value   div_divisor;
    t_div_res div_res;
    t_emit    emit;
    logic     emit_ready;

    logic     r_valid;
    t_value   r_factor;
    logic     r_last;
    logic     r_status;

    pf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_number       (s_axis_tdata[VALUE_BITS-1:0]),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div          (div_res),
        .o_emit         (emit),
        .i_emit_ready   (emit_ready)
    );

    pf_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    // The output register takes a new word whenever it is empty or being drained,
    // so the sequencer never waits longer than the downstream stall.
    assign emit_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit_ready) begin
            r_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit.valid) begin
            r_factor <= emit.factor;
            r_last   <= emit.last;
            r_status <= emit.status;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = DATA_BITS'(r_factor);
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire
